### design/dqpid_pkg.sv
`timescale 1ns / 1ps

package dqpid_pkg;

    // sequencer steps; every step but idle, sq and out issues one multiply
    typedef enum logic [3:0] {
        S_IDLE,
        S_AQ,
        S_AD,
        S_FQL,
        S_FQH,
        S_FDL,
        S_FDH,
        S_PD,
        S_ID,
        S_DD,
        S_PQ,
        S_IQ,
        S_DQ,
        S_SQ,
        S_OUT
    } t_state;

    // configuration register indexes
    typedef enum logic [2:0] {
        REG_GAIN_P      = 3'd0,
        REG_GAIN_I      = 3'd1,
        REG_GAIN_D      = 3'd2,
        REG_INTEG_LIMIT = 3'd3,
        REG_OUT_LIMIT   = 3'd4,
        REG_IND_COEFF   = 3'd5,
        REG_FLUX_COEFF  = 3'd6
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [15:0] RST_GAIN_P      = 16'd256;
    localparam logic [15:0] RST_GAIN_I      = 16'd0;
    localparam logic [15:0] RST_GAIN_D      = 16'd0;
    localparam logic [14:0] RST_INTEG_LIMIT = 15'd3072;
    localparam logic [14:0] RST_OUT_LIMIT   = 15'd3072;
    localparam logic [23:0] RST_IND_COEFF   = 24'd0;
    localparam logic [23:0] RST_FLUX_COEFF  = 24'd0;

    // symmetric clamp to +-lim
    function automatic logic signed [15:0] f_clamp(input logic signed [47:0] v,
                                                   input logic [14:0]        lim);
        logic signed [47:0] pos;
        logic signed [47:0] neg;
        pos = $signed({33'd0, lim});
        neg = -pos;
        priority if (v > pos) begin
            return pos[15:0];
        end else if (v < neg) begin
            return neg[15:0];
        end else begin
            return v[15:0];
        end
    endfunction

endpackage

### design/dq_current_pid_decoupled.sv
// dq current controller with speed-dependent decoupling feed-forward. each request carries
// the d/q current references, the measured d/q currents and the rotor speed, and gives one
// result with the d/q voltage commands (q7.8, clamped to +-out_limit). both axes run a pid
// with the integrator clamped to +-integ_limit; the q axis adds speed*(ind*id+flux) and the
// d axis subtracts speed*ind*iq, each term clamped to +-integ_limit first. all products go
// through a single 18x25 signed multiplier with a registered product, stepped by a small
// sequencer that runs 14 steps after idle, 12 of them multiplies, before a result waits.
// the input is stalled while a request is being worked on; a finished result sits in
// the output register, so the next request can be accepted while it waits.
// configuration writes are taken every cycle and must only be issued while the block is
// idle; writes to an unknown index are ignored.
`timescale 1ns / 1ps

module dq_current_pid_decoupled (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dqpid_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [dqpid_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    // input request channel
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic signed [15:0]                 i_id_ref,
    input  logic signed [15:0]                 i_iq_ref,
    input  logic signed [15:0]                 i_id_meas,
    input  logic signed [15:0]                 i_iq_meas,
    input  logic signed [15:0]                 i_rotor_speed,
    // result channel
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic signed [15:0]                 o_vd,
    output logic signed [15:0]                 o_vq
);

    import dqpid_pkg::*;

    // sequencer
    t_state r_state;
    t_state n_state;

    // configuration registers
    logic [15:0] r_gain_p;
    logic [15:0] r_gain_i;
    logic [15:0] r_gain_d;
    logic [14:0] r_integ_limit;
    logic [14:0] r_out_limit;
    logic [23:0] r_ind_coeff;
    logic [23:0] r_flux_coeff;

    // controller state kept across requests
    logic signed [16:0] r_integ_d;
    logic signed [16:0] r_integ_q;
    logic signed [16:0] r_prev_err_d;
    logic signed [16:0] r_prev_err_q;

    // captured request
    logic signed [15:0] r_id_meas;
    logic signed [15:0] r_iq_meas;
    logic signed [15:0] r_speed;
    logic signed [16:0] r_err_d;
    logic signed [16:0] r_err_q;

    // working registers
    logic signed [42:0] r_prod;     // registered multiplier output
    logic signed [41:0] r_aq;       // ind*id_meas + 256*flux
    logic signed [41:0] r_ad;       // ind*iq_meas
    logic signed [18:0] r_ffp;      // low half of the speed product, already floored
    logic signed [15:0] r_ffq;
    logic signed [15:0] r_ffd;
    logic signed [27:0] r_sum;      // p + integ + d of the axis in progress
    logic signed [15:0] r_vd;

    // shared multiplier operands
    logic signed [17:0] w_mul_a;
    logic signed [24:0] w_mul_b;

    logic               w_in_acc;
    logic               w_out_load;
    logic signed [47:0] w_sh8;      // floor(product / 256)
    logic signed [18:0] w_sh24;     // floor(product / 2^24)
    logic signed [47:0] w_ff_sum;

    assign o_cfg_ready = 1'b1;
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_sh8       = 48'($signed(r_prod[42:8]));
    assign w_sh24      = $signed(r_prod[42:24]);
    assign w_ff_sum    = 48'(r_ffp) + 48'(r_prod);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (w_in_acc) n_state = S_AQ;
            S_AQ:    n_state = S_AD;
            S_AD:    n_state = S_FQL;
            S_FQL:   n_state = S_FQH;
            S_FQH:   n_state = S_FDL;
            S_FDL:   n_state = S_FDH;
            S_FDH:   n_state = S_PD;
            S_PD:    n_state = S_ID;
            S_ID:    n_state = S_DD;
            S_DD:    n_state = S_PQ;
            S_PQ:    n_state = S_IQ;
            S_IQ:    n_state = S_DQ;
            S_DQ:    n_state = S_SQ;
            S_SQ:    n_state = S_OUT;
            S_OUT:   if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // sequencer outputs: stall, result load and multiplier operand selection
    always_comb begin
        o_in_stall = (r_state != S_IDLE);
        w_out_load = (r_state == S_OUT) && (!o_out_valid || !i_out_stall);
        w_mul_a    = '0;
        w_mul_b    = '0;
        unique case (r_state)
            S_AQ: begin
                w_mul_a = 18'(r_id_meas);
                w_mul_b = $signed({1'b0, r_ind_coeff});
            end
            S_AD: begin
                w_mul_a = 18'(r_iq_meas);
                w_mul_b = $signed({1'b0, r_ind_coeff});
            end
            S_FQL: begin
                w_mul_a = 18'(r_speed);
                w_mul_b = $signed({1'b0, r_aq[23:0]});
            end
            S_FQH: begin
                w_mul_a = $signed(r_aq[41:24]);
                w_mul_b = 25'(r_speed);
            end
            S_FDL: begin
                w_mul_a = 18'(r_speed);
                w_mul_b = $signed({1'b0, r_ad[23:0]});
            end
            S_FDH: begin
                w_mul_a = $signed(r_ad[41:24]);
                w_mul_b = 25'(r_speed);
            end
            S_PD: begin
                w_mul_a = 18'(r_err_d);
                w_mul_b = $signed({9'd0, r_gain_p});
            end
            S_ID: begin
                w_mul_a = 18'(r_err_d);
                w_mul_b = $signed({9'd0, r_gain_i});
            end
            S_DD: begin
                w_mul_a = 18'(r_err_d) - 18'(r_prev_err_d);
                w_mul_b = $signed({9'd0, r_gain_d});
            end
            S_PQ: begin
                w_mul_a = 18'(r_err_q);
                w_mul_b = $signed({9'd0, r_gain_p});
            end
            S_IQ: begin
                w_mul_a = 18'(r_err_q);
                w_mul_b = $signed({9'd0, r_gain_i});
            end
            S_DQ: begin
                w_mul_a = 18'(r_err_q) - 18'(r_prev_err_q);
                w_mul_b = $signed({9'd0, r_gain_d});
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    // control registers, configuration and controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            o_out_valid   <= 1'b0;
            r_gain_p      <= RST_GAIN_P;
            r_gain_i      <= RST_GAIN_I;
            r_gain_d      <= RST_GAIN_D;
            r_integ_limit <= RST_INTEG_LIMIT;
            r_out_limit   <= RST_OUT_LIMIT;
            r_ind_coeff   <= RST_IND_COEFF;
            r_flux_coeff  <= RST_FLUX_COEFF;
            r_integ_d     <= '0;
            r_integ_q     <= '0;
            r_prev_err_d  <= '0;
            r_prev_err_q  <= '0;
        end else begin
            r_state <= n_state;

            // result register: taken result clears, fresh result sets
            if (w_out_load) begin
                o_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                o_out_valid <= 1'b0;
            end

            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    REG_GAIN_P:      r_gain_p      <= i_cfg_data[15:0];
                    REG_GAIN_I:      r_gain_i      <= i_cfg_data[15:0];
                    REG_GAIN_D:      r_gain_d      <= i_cfg_data[15:0];
                    REG_INTEG_LIMIT: r_integ_limit <= i_cfg_data[14:0];
                    REG_OUT_LIMIT:   r_out_limit   <= i_cfg_data[14:0];
                    REG_IND_COEFF:   r_ind_coeff   <= i_cfg_data[23:0];
                    REG_FLUX_COEFF:  r_flux_coeff  <= i_cfg_data[23:0];
                    default: ;
                endcase
            end

            // integrators are clamped again after each increment
            if (r_state == S_DD) begin
                r_integ_d <= 17'(f_clamp(48'(r_integ_d) + w_sh8, r_integ_limit));
            end
            if (r_state == S_DQ) begin
                r_integ_q <= 17'(f_clamp(48'(r_integ_q) + w_sh8, r_integ_limit));
            end
            if (r_state == S_PQ) begin
                r_prev_err_d <= r_err_d;
            end
            if (r_state == S_SQ) begin
                r_prev_err_q <= r_err_q;
            end
        end
    end

    // datapath: each step consumes the product issued by the step before
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;

        if (w_in_acc) begin
            r_id_meas <= i_id_meas;
            r_iq_meas <= i_iq_meas;
            r_speed   <= i_rotor_speed;
            r_err_d   <= 17'(i_id_ref) - 17'(i_id_meas);
            r_err_q   <= 17'(i_iq_ref) - 17'(i_iq_meas);
        end

        unique case (r_state)
            S_AD:  r_aq  <= r_prod[41:0] + {10'd0, r_flux_coeff, 8'd0};
            S_FQL: r_ad  <= r_prod[41:0];
            S_FQH: r_ffp <= w_sh24;
            S_FDL: r_ffq <= f_clamp(w_ff_sum, r_integ_limit);
            S_FDH: r_ffp <= w_sh24;
            S_PD:  r_ffd <= f_clamp(w_ff_sum, r_integ_limit);
            S_ID:  r_sum <= 28'(w_sh8);
            // integrator of d is updated in S_DD by the control block
            S_PQ:  r_sum <= 28'(48'(r_sum) + 48'(r_integ_d) + w_sh8);
            S_IQ: begin
                r_vd  <= f_clamp(48'(r_sum) - 48'(r_ffd), r_out_limit);
                r_sum <= 28'(w_sh8);
            end
            // integrator of q is updated in S_DQ by the control block
            S_SQ:  r_sum <= 28'(48'(r_sum) + 48'(r_integ_q) + w_sh8);
            default: ;
        endcase

        if (w_out_load) begin
            o_vd <= r_vd;
            o_vq <= f_clamp(48'(r_sum) + 48'(r_ffq), r_out_limit);
        end
    end

`ifndef NO_ASSERTIONS
    // results always respect the output clamp
    a_out_in_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed(o_vd) <= $signed({2'b00, r_out_limit}))
                     && ($signed(o_vd) >= -$signed({2'b00, r_out_limit}))
                     && ($signed(o_vq) <= $signed({2'b00, r_out_limit}))
                     && ($signed(o_vq) >= -$signed({2'b00, r_out_limit})))
        else $error("voltage command outside output limit");

    // a fresh result only appears after the last sequencer step
    a_result_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_OUT))
        else $error("result raised outside the output step");

    // a finished result is held back, not dropped, while the previous one is stalled
    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && o_out_valid && i_out_stall) |=> (r_state == S_OUT))
        else $error("sequencer left the output step while the result was stalled");
`endif

endmodule

### bench/dq_current_pid_decoupled_test.sv
`timescale 1ns / 1ps

module dq_current_pid_decoupled_test;
    import dqpid_pkg::*;

    // run shape
    localparam int RESET_CYCLES    = 4;
    localparam int SETTLE_CYCLES   = 20;   // extra wait before register writes
    localparam int DRAIN_CYCLES    = 40;
    localparam int IDLE_LIMIT      = 5000; // cycles with no handshake of any kind
    localparam int RANDOM_PHASES   = 8;
    localparam int ITEMS_PER_PHASE = 80;
    localparam int HOLD_CYCLES     = 300;  // long receiver hold-off
    localparam int FIRST_HOLD_AT   = 120;
    localparam int SECOND_HOLD_AT  = 420;

    // index outside the register map, writes to it must be dropped
    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    localparam int AXIS_D = 0;
    localparam int AXIS_Q = 1;

    typedef enum {SINK_EAGER, SINK_COIN, SINK_SLUGGISH, SINK_PERIODIC} t_sink_mode;

    typedef struct {
        logic signed [15:0] id_ref;
        logic signed [15:0] iq_ref;
        logic signed [15:0] id_meas;
        logic signed [15:0] iq_meas;
        logic signed [15:0] rotor_speed;
    } t_dq_request;

    typedef struct {
        logic signed [15:0] vd;
        logic signed [15:0] vq;
    } t_volts;

    typedef struct {
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_write;

    // mirror of the controller: settings, integrators and last errors, plus the
    // queue of voltage commands still owed by the block
    class voltage_checker;
        logic [15:0]        gain_p;
        logic [15:0]        gain_i;
        logic [15:0]        gain_d;
        logic [14:0]        integ_limit;
        logic [14:0]        out_limit;
        logic [23:0]        ind_coeff;
        logic [23:0]        flux_coeff;
        logic signed [16:0] integ [2];
        logic signed [16:0] prev_err [2];
        t_volts             awaited_volts [$];
        int unsigned        failures;
        int unsigned        checked;

        function new();
            gain_p      = RST_GAIN_P;
            gain_i      = RST_GAIN_I;
            gain_d      = RST_GAIN_D;
            integ_limit = RST_INTEG_LIMIT;
            out_limit   = RST_OUT_LIMIT;
            ind_coeff   = RST_IND_COEFF;
            flux_coeff  = RST_FLUX_COEFF;
            foreach (integ[a]) begin
                integ[a]    = '0;
                prev_err[a] = '0;
            end
            failures = 0;
            checked  = 0;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_GAIN_P:      gain_p      = data[15:0];
                REG_GAIN_I:      gain_i      = data[15:0];
                REG_GAIN_D:      gain_d      = data[15:0];
                REG_INTEG_LIMIT: integ_limit = data[14:0];
                REG_OUT_LIMIT:   out_limit   = data[14:0];
                REG_IND_COEFF:   ind_coeff   = data[23:0];
                REG_FLUX_COEFF:  flux_coeff  = data[23:0];
                default: ;
            endcase
        endfunction

        function longint clamp_mag(longint v, logic [14:0] lim);
            longint l;
            l = longint'(lim);
            if (v > l) return l;
            if (v < -l) return -l;
            return v;
        endfunction

        // p + clamped integrator + d for one axis; >>> on a signed longint floors
        function longint pid_sum(int axis, longint err);
            longint p;
            longint i;
            longint d;
            p = (longint'(gain_p) * err) >>> 8;
            i = clamp_mag(longint'(integ[axis]) + ((longint'(gain_i) * err) >>> 8), integ_limit);
            d = (longint'(gain_d) * (err - longint'(prev_err[axis]))) >>> 8;
            integ[axis]    = 17'(i);
            prev_err[axis] = 17'(err);
            return p + i + d;
        endfunction

        function t_volts predict_volts(t_dq_request r);
            longint speed;
            longint ffq;
            longint ffd;
            longint sd;
            longint sq;
            t_volts v;
            speed = longint'(r.rotor_speed);
            ffq = clamp_mag((speed * (longint'(ind_coeff) * longint'(r.id_meas)
                                      + longint'(flux_coeff) * 256)) >>> 24, integ_limit);
            ffd = clamp_mag((speed * longint'(ind_coeff) * longint'(r.iq_meas)) >>> 24,
                            integ_limit);
            sd = pid_sum(AXIS_D, longint'(r.id_ref) - longint'(r.id_meas)) - ffd;
            sq = pid_sum(AXIS_Q, longint'(r.iq_ref) - longint'(r.iq_meas)) + ffq;
            v.vd = 16'(clamp_mag(sd, out_limit));
            v.vq = 16'(clamp_mag(sq, out_limit));
            return v;
        endfunction

        function void note_request(t_dq_request r);
            awaited_volts.push_back(predict_volts(r));
        endfunction

        function void check_result(logic signed [15:0] vd, logic signed [15:0] vq);
            t_volts want;
            checked++;
            if (awaited_volts.size() == 0) begin
                $error("result with no request outstanding: vd %0d vq %0d", vd, vq);
                failures++;
                return;
            end
            want = awaited_volts.pop_front();
            if (vd !== want.vd) begin
                $error("vd mismatch: expected %0d, actual %0d", want.vd, vd);
                failures++;
            end
            if (vq !== want.vq) begin
                $error("vq mismatch: expected %0d, actual %0d", want.vq, vq);
                failures++;
            end
        endfunction

        function int outstanding();
            return awaited_volts.size();
        endfunction
    endclass

    // every input starts at a known value
    logic                  i_clk         = 1'b0;
    logic                  i_rst_n       = 1'b0;
    logic                  i_cfg_valid   = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data    = '0;
    logic                  i_in_valid    = 1'b0;
    logic                  o_in_stall;
    logic signed [15:0]    i_id_ref      = '0;
    logic signed [15:0]    i_iq_ref      = '0;
    logic signed [15:0]    i_id_meas     = '0;
    logic signed [15:0]    i_iq_meas     = '0;
    logic signed [15:0]    i_rotor_speed = '0;
    logic                  o_out_valid;
    logic                  i_out_stall   = 1'b0;
    logic signed [15:0]    o_vd;
    logic signed [15:0]    o_vq;

    voltage_checker book = new();

    t_cfg_write reg_writes [$];
    int         burst_left = 1;
    int         idle_cycles = 0;

    dq_current_pid_decoupled DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_id_ref      (i_id_ref),
        .i_iq_ref      (i_iq_ref),
        .i_id_meas     (i_id_meas),
        .i_iq_meas     (i_iq_meas),
        .i_rotor_speed (i_rotor_speed),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_vd          (o_vd),
        .o_vq          (o_vq)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // results are sampled at the edge, before any of this edge's updates land
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            book.check_result(o_vd, o_vq);
        end
    end

    // watchdog: ends the run if no handshake happens for too long
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)
                || (i_cfg_valid && o_cfg_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("[dq_current_pid_decoupled] ERROR");
            $finish;
        end
    end

    // result side: switches among random stall modes, and twice holds
    // off for a long stretch so the block backs up and stalls its input
    initial begin : result_sink
        t_sink_mode mode;
        int         mode_left;
        int         tick;
        int         hold_left;
        int         holds_done;
        logic       stall;
        mode       = SINK_EAGER;
        mode_left  = 0;
        tick       = 0;
        hold_left  = 0;
        holds_done = 0;
        forever begin
            @(posedge i_clk);
            if (hold_left == 0 && holds_done < 2
                    && book.checked >= (holds_done == 0 ? FIRST_HOLD_AT : SECOND_HOLD_AT)) begin
                hold_left = HOLD_CYCLES;
                holds_done++;
            end
            if (mode_left == 0) begin
                mode      = t_sink_mode'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 96);
            end
            mode_left--;
            tick++;
            if (hold_left != 0) begin
                stall = 1'b1;
                hold_left--;
            end else begin
                case (mode)
                    SINK_EAGER:    stall = 1'b0;
                    SINK_COIN:     stall = 1'($urandom_range(0, 1));
                    SINK_SLUGGISH: stall = ($urandom_range(0, 4) != 0);
                    default:       stall = (tick % 4 != 0);
                endcase
            end
            i_out_stall <= stall;
        end
    end

    function automatic t_dq_request make_request(int id_ref, int iq_ref, int id_meas,
                                                 int iq_meas, int speed);
        t_dq_request r;
        r.id_ref      = 16'(id_ref);
        r.iq_ref      = 16'(iq_ref);
        r.id_meas     = 16'(id_meas);
        r.iq_meas     = 16'(iq_meas);
        r.rotor_speed = 16'(speed);
        return r;
    endfunction

    // mix of rails, small values and the full range
    function automatic logic signed [15:0] pick_current();
        case ($urandom_range(0, 9))
            0:       return 16'sh7fff;
            1:       return 16'sh8000;
            2, 3, 4: return 16'($signed($urandom_range(0, 4095)) - 2048);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0:          return 16'sh7fff;
            1:          return 16'sh8000;
            2:          return '0;
            3, 4, 5, 6: return 16'($signed($urandom_range(0, 4000)) - 2000);
            default:    return 16'($urandom);
        endcase
    endfunction

    // about half the requests track the reference closely so the integrator and
    // derivative stay out of the rails
    function automatic t_dq_request random_request();
        t_dq_request r;
        r.id_ref      = pick_current();
        r.iq_ref      = pick_current();
        r.rotor_speed = pick_speed();
        if ($urandom_range(0, 1) == 0) begin
            r.id_meas = 16'(int'(r.id_ref) + $signed($urandom_range(0, 512)) - 256);
            r.iq_meas = 16'(int'(r.iq_ref) + $signed($urandom_range(0, 512)) - 256);
        end else begin
            r.id_meas = pick_current();
            r.iq_meas = pick_current();
        end
        return r;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_gain();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 24'hffff;
            2, 3, 4: return 24'($urandom_range(0, 1024));
            default: return 24'($urandom);
        endcase
    endfunction

    // upper data bits are left as noise now and then, the register only keeps 15
    function automatic logic [CFG_DATA_W-1:0] pick_limit();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 24'h7fff;
            2, 3:    return 24'($urandom_range(256, 8192));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_coeff();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return 24'hffffff;
            2, 3, 4: return 24'($urandom_range(0, 4095));
            default: return 24'($urandom);
        endcase
    endfunction

    function automatic void queue_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        t_cfg_write w;
        w.idx  = idx;
        w.data = data;
        reg_writes.push_back(w);
    endfunction

    // one request; valid stays up through a burst and drops for a random gap after it
    task automatic offer(t_dq_request r);
        i_id_ref      <= r.id_ref;
        i_iq_ref      <= r.iq_ref;
        i_id_meas     <= r.id_meas;
        i_iq_meas     <= r.iq_meas;
        i_rotor_speed <= r.rotor_speed;
        i_in_valid    <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        book.note_request(r);
        burst_left--;
        if (burst_left <= 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 20)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    task automatic close_burst();
        if (i_in_valid) begin
            i_in_valid <= 1'b0;
        end
    endtask

    // registers only change with nothing in flight
    task automatic commit_regs();
        t_cfg_write w;
        close_burst();
        while (book.outstanding() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        while (reg_writes.size() != 0) begin
            w = reg_writes.pop_front();
            i_cfg_valid <= 1'b1;
            i_cfg_index <= w.idx;
            i_cfg_data  <= w.data;
            do @(posedge i_clk); while (!o_cfg_ready);
            book.write_reg(w.idx, w.data);
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic directed_items();
        // reset settings: zero, the largest errors either way, a modest error
        offer(make_request(0, 0, 0, 0, 0));
        offer(make_request(32767, -32768, -32768, 32767, 32767));
        offer(make_request(100, -50, 40, 20, -32768));

        // every register at its top value
        queue_reg(REG_GAIN_P, 24'hffff);
        queue_reg(REG_GAIN_I, 24'hffff);
        queue_reg(REG_GAIN_D, 24'hffff);
        queue_reg(REG_INTEG_LIMIT, 24'h7fff);
        queue_reg(REG_OUT_LIMIT, 24'h7fff);
        queue_reg(REG_IND_COEFF, 24'hffffff);
        queue_reg(REG_FLUX_COEFF, 24'hffffff);
        commit_regs();
        offer(make_request(32767, 32767, -32768, -32768, 32767));
        offer(make_request(-32768, -32768, 32767, 32767, -32768));
        offer(make_request(-32768, 32767, -32768, 32767, 32767));
        offer(make_request(0, 0, 0, 0, -32768));

        // a write to an unmapped index leaves everything alone
        queue_reg(CFG_IDX_SPARE, 24'h000000);
        commit_regs();
        offer(make_request(1, -1, 0, 0, 1));

        // zero limits pin the integrator, both feed-forwards and the outputs to zero
        queue_reg(REG_INTEG_LIMIT, 24'h000000);
        queue_reg(REG_OUT_LIMIT, 24'h000000);
        commit_regs();
        offer(make_request(32767, -32768, -32768, 32767, 32767));
        offer(make_request(-5, 5, 5, -5, -7));

        // integrator runs into its limit, then the limit is lowered under it
        queue_reg(REG_GAIN_P, 24'h0000);
        queue_reg(REG_GAIN_I, 24'h0100);
        queue_reg(REG_GAIN_D, 24'h0000);
        queue_reg(REG_INTEG_LIMIT, 24'd20000);
        queue_reg(REG_OUT_LIMIT, 24'h7fff);
        queue_reg(REG_IND_COEFF, 24'h000000);
        queue_reg(REG_FLUX_COEFF, 24'h000000);
        commit_regs();
        offer(make_request(8000, -8000, 0, 0, 0));
        offer(make_request(8000, -8000, 0, 0, 0));
        offer(make_request(8000, -8000, 0, 0, 0));
        queue_reg(REG_INTEG_LIMIT, 24'd5000);
        commit_regs();
        offer(make_request(-1000, 1000, 0, 0, 0));

        // feed-forward inside its clamp, both signs of speed and current
        queue_reg(REG_GAIN_P, 24'h0100);
        queue_reg(REG_GAIN_D, 24'h0080);
        queue_reg(REG_INTEG_LIMIT, 24'h7fff);
        queue_reg(REG_IND_COEFF, 24'h010000);
        queue_reg(REG_FLUX_COEFF, 24'h008000);
        commit_regs();
        offer(make_request(256, 512, 200, 480, 100));
        offer(make_request(-256, -512, -300, -500, -100));
        offer(make_request(0, 0, 1000, -1000, 1500));
    endtask

    // settings for one random phase: top values, bottom values, then random
    function automatic void pick_settings(int phase);
        if (phase == 0) begin
            queue_reg(REG_GAIN_P, 24'hffffff);
            queue_reg(REG_GAIN_I, 24'hffffff);
            queue_reg(REG_GAIN_D, 24'hffffff);
            queue_reg(REG_INTEG_LIMIT, 24'hffffff);
            queue_reg(REG_OUT_LIMIT, 24'hffffff);
            queue_reg(REG_IND_COEFF, 24'hffffff);
            queue_reg(REG_FLUX_COEFF, 24'hffffff);
        end else if (phase == 1) begin
            queue_reg(REG_GAIN_P, 24'h000000);
            queue_reg(REG_GAIN_I, 24'h000000);
            queue_reg(REG_GAIN_D, 24'h000000);
            queue_reg(REG_INTEG_LIMIT, 24'h000000);
            queue_reg(REG_OUT_LIMIT, 24'h000000);
            queue_reg(REG_IND_COEFF, 24'h000000);
            queue_reg(REG_FLUX_COEFF, 24'h000000);
        end else begin
            queue_reg(REG_GAIN_P, pick_gain());
            queue_reg(REG_GAIN_I, pick_gain());
            queue_reg(REG_GAIN_D, pick_gain());
            queue_reg(REG_INTEG_LIMIT, pick_limit());
            queue_reg(REG_OUT_LIMIT, pick_limit());
            queue_reg(REG_IND_COEFF, pick_coeff());
            queue_reg(REG_FLUX_COEFF, pick_coeff());
            if ($urandom_range(0, 2) == 0) begin
                queue_reg(CFG_IDX_SPARE, 24'($urandom));
            end
        end
    endfunction

    initial begin : stimulus
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        directed_items();
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            pick_settings(phase);
            commit_regs();
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                offer(random_request());
            end
        end
        close_burst();
        while (book.outstanding() != 0) @(posedge i_clk);
        // a stray late result would still be caught here
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (book.failures == 0) begin
            $display("[dq_current_pid_decoupled] OK");
        end else begin
            $display("[dq_current_pid_decoupled] ERROR");
        end
        $finish;
    end

endmodule
